### rtl/tose_pkg.sv
// Types and constants shared by the tagged operand stack engine.
// No dependencies.
`default_nettype none

package tose_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH    = 3'd0,
		CMD_DROP    = 3'd1,
		CMD_DUP     = 3'd2,
		CMD_SWAP    = 3'd3,
		CMD_ROT     = 3'd4,
		CMD_PICK    = 3'd5,
		CMD_TO_INT  = 3'd6,
		CMD_TO_CHAR = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2,
		ERR_PICK  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_UP,
		CELL_FROM_DOWN
	} cell_op_t;

	typedef enum logic [1:0] {
		CARRY_HOLD,
		CARRY_LOAD,
		CARRY_SHIFT
	} carry_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEEK
	} state_t;

	typedef struct packed {
		logic [63:0] value;
		logic        is_char;
	} entry_t;

	typedef struct packed {
		cell_op_t  op;
		carry_op_t carry_op;
	} cell_ctrl_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [63:0] push_value;
		logic               push_is_char;
	} request_t;

	typedef struct packed {
		logic signed [63:0] top_value;
		logic               top_is_char;
		logic [8:0]         depth;
		err_t               error;
	} result_t;

	localparam int unsigned HEAD_CELLS = 3;

endpackage

`default_nettype wire

### rtl/tose_cell.sv
// One stack cell: holds one entry and one carry word of the pick chain.
// Depends on tose_pkg.
`default_nettype none

module tose_cell (
	input  wire logic               clk,
	input  wire tose_pkg::cell_ctrl_t ctrl,
	input  wire tose_pkg::entry_t   up_entry,
	input  wire tose_pkg::entry_t   down_entry,
	input  wire tose_pkg::entry_t   down_carry,
	output tose_pkg::entry_t        entry,
	output tose_pkg::entry_t        carry
);
	import tose_pkg::*;

	entry_t entry_q;
	entry_t carry_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_FROM_UP:   entry_q <= up_entry;
			CELL_FROM_DOWN: entry_q <= down_entry;
			default:        entry_q <= entry_q;
		endcase
		case (ctrl.carry_op)
			CARRY_LOAD:  carry_q <= down_entry;
			CARRY_SHIFT: carry_q <= down_carry;
			default:     carry_q <= carry_q;
		endcase
	end

	assign entry = entry_q;
	assign carry = carry_q;

endmodule

`default_nettype wire

### rtl/tose_ctrl.sv
// Command sequencer: stack pointer, error checks, cell control and result.
// Depends on tose_pkg.
`default_nettype none

module tose_ctrl #(
	parameter int unsigned STACK_DEPTH = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire tose_pkg::request_t                  req,
	output logic                                     done,
	output tose_pkg::result_t                        rsp,
	input  wire tose_pkg::entry_t                    top_entry,
	input  wire tose_pkg::entry_t                    second_entry,
	input  wire tose_pkg::entry_t                    third_entry,
	input  wire tose_pkg::entry_t                    top_carry,
	output tose_pkg::entry_t                         load_entry,
	output tose_pkg::cell_ctrl_t [tose_pkg::HEAD_CELLS-1:0] head_ctrl,
	output tose_pkg::cell_ctrl_t                     rest_ctrl
);
	import tose_pkg::*;

	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW  = $clog2(STACK_DEPTH);

	state_t          state_q, state_d;
	logic [SPW-1:0]  sp_q, sp_d;
	logic [AW-1:0]   cnt_q, cnt_d;
	logic            done_q, done_d;
	err_t            err_q, err_d;

	logic            accept;
	logic            under;
	logic            full;
	logic            pick_ok;
	logic [1:0]      need;
	logic [SPW-1:0]  below;
	cell_ctrl_t      hold_ctrl;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign full   = (sp_q == SPW'(STACK_DEPTH));
	assign below  = sp_q - SPW'(1);

	always_comb begin
		unique case (req.cmd)
			CMD_PUSH: need = 2'd0;
			CMD_SWAP: need = 2'd2;
			CMD_ROT:  need = 2'd3;
			default:  need = 2'd1;
		endcase
	end

	assign under   = (sp_q < SPW'(need));
	assign pick_ok = (top_entry.value < 64'(below));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !under && (req.cmd == CMD_PICK) && pick_ok) begin
					state_d = ST_SEEK;
				end
			end
			ST_SEEK: begin
				if (cnt_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		hold_ctrl  = '{op: CELL_HOLD, carry_op: CARRY_HOLD};
		head_ctrl  = {HEAD_CELLS{hold_ctrl}};
		rest_ctrl  = hold_ctrl;
		load_entry = top_entry;
		sp_d       = sp_q;
		cnt_d      = cnt_q;
		err_d      = err_q;
		done_d     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					err_d  = ERR_OK;
					if (under) begin
						err_d = ERR_UNDER;
					end else begin
						unique case (req.cmd)
							CMD_PUSH: begin
								if (full) begin
									err_d = ERR_OVER;
								end else begin
									head_ctrl[0].op = CELL_FROM_UP;
									head_ctrl[1].op = CELL_FROM_UP;
									head_ctrl[2].op = CELL_FROM_UP;
									rest_ctrl.op    = CELL_FROM_UP;
									load_entry.is_char = req.push_is_char;
									load_entry.value   = req.push_is_char ?
										{56'd0, req.push_value[7:0]} : req.push_value;
									sp_d = sp_q + SPW'(1);
								end
							end
							CMD_DROP: begin
								head_ctrl[0].op = CELL_FROM_DOWN;
								head_ctrl[1].op = CELL_FROM_DOWN;
								head_ctrl[2].op = CELL_FROM_DOWN;
								rest_ctrl.op    = CELL_FROM_DOWN;
								sp_d = sp_q - SPW'(1);
							end
							CMD_DUP: begin
								if (full) begin
									err_d = ERR_OVER;
								end else begin
									head_ctrl[1].op = CELL_FROM_UP;
									head_ctrl[2].op = CELL_FROM_UP;
									rest_ctrl.op    = CELL_FROM_UP;
									sp_d = sp_q + SPW'(1);
								end
							end
							CMD_SWAP: begin
								head_ctrl[0].op = CELL_FROM_UP;
								head_ctrl[1].op = CELL_FROM_UP;
								load_entry      = second_entry;
							end
							CMD_ROT: begin
								head_ctrl[0].op = CELL_FROM_UP;
								head_ctrl[1].op = CELL_FROM_UP;
								head_ctrl[2].op = CELL_FROM_UP;
								load_entry      = third_entry;
							end
							CMD_PICK: begin
								if (!pick_ok) begin
									err_d = ERR_PICK;
								end else begin
									done_d = 1'b0;
									head_ctrl[0].carry_op = CARRY_LOAD;
									head_ctrl[1].carry_op = CARRY_LOAD;
									head_ctrl[2].carry_op = CARRY_LOAD;
									rest_ctrl.carry_op    = CARRY_LOAD;
									cnt_d = top_entry.value[AW-1:0];
								end
							end
							CMD_TO_INT: begin
								head_ctrl[0].op    = CELL_FROM_UP;
								load_entry.is_char = 1'b0;
							end
							CMD_TO_CHAR: begin
								head_ctrl[0].op  = CELL_FROM_UP;
								load_entry.value   = {56'd0, top_entry.value[7:0]};
								load_entry.is_char = 1'b1;
							end
							default: err_d = ERR_OK;
						endcase
					end
				end
			end
			ST_SEEK: begin
				if (cnt_q == '0) begin
					head_ctrl[0].op = CELL_FROM_UP;
					load_entry      = top_carry;
					done_d          = 1'b1;
				end else begin
					head_ctrl[0].carry_op = CARRY_SHIFT;
					head_ctrl[1].carry_op = CARRY_SHIFT;
					head_ctrl[2].carry_op = CARRY_SHIFT;
					rest_ctrl.carry_op    = CARRY_SHIFT;
					cnt_d = cnt_q - AW'(1);
				end
			end
			default: done_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			err_q   <= ERR_OK;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
			err_q   <= err_d;
		end
	end

	assign done = done_q;

	always_comb begin
		rsp.top_value   = (sp_q != '0) ? top_entry.value : 64'd0;
		rsp.top_is_char = (sp_q != '0) ? top_entry.is_char : 1'b0;
		rsp.depth       = 9'(sp_q);
		rsp.error       = err_q;
	end

endmodule

`default_nettype wire

### rtl/tagged_operand_stack_engine_top.sv
// Tagged operand stack engine: sequencer and a chain of stack cells, top at cell 0.
// Depends on tose_pkg, tose_cell and tose_ctrl.
// The result is registered and given in the cycle after the request for every command
// but a good pick, whose copy of item n first walks up the carry chain in ST_SEEK.
// Throughput: one request per cycle except during a pick; results cannot be stalled.
// Reset empties the stack; entry contents are not cleared.
`default_nettype none

module tagged_operand_stack_engine_top #(
	parameter int unsigned STACK_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire tose_pkg::request_t req,
	output logic                    done,
	output tose_pkg::result_t       rsp
);
	import tose_pkg::*;

	entry_t     entries [STACK_DEPTH];
	entry_t     carries [STACK_DEPTH];
	entry_t     load_entry;
	cell_ctrl_t [HEAD_CELLS-1:0] head_ctrl;
	cell_ctrl_t rest_ctrl;

	tose_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.top_entry   (entries[0]),
		.second_entry(entries[1]),
		.third_entry (entries[2]),
		.top_carry   (carries[0]),
		.load_entry  (load_entry),
		.head_ctrl   (head_ctrl),
		.rest_ctrl   (rest_ctrl)
	);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		entry_t     up_entry;
		entry_t     down_entry;
		entry_t     down_carry;

		if (i < HEAD_CELLS) begin : g_head
			assign ctrl = head_ctrl[i];
		end else begin : g_rest
			assign ctrl = rest_ctrl;
		end

		if (i == 0) begin : g_first
			assign up_entry = load_entry;
		end else begin : g_inner
			assign up_entry = entries[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign down_entry = '0;
			assign down_carry = '0;
		end else begin : g_link
			assign down_entry = entries[i+1];
			assign down_carry = carries[i+1];
		end

		tose_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.up_entry  (up_entry),
			.down_entry(down_entry),
			.down_carry(down_carry),
			.entry     (entries[i]),
			.carry     (carries[i])
		);
	end

endmodule

`default_nettype wire

### verif/tagged_operand_stack_engine_top_test.sv
// Self-checking testbench for the tagged operand stack engine: every command, underflow,
// overflow and pick index cases, then shaped random command streams under sender idling.
// Depends on tose_pkg and tagged_operand_stack_engine_top.
`default_nettype none

module tagged_operand_stack_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tose_pkg::*;

	localparam int unsigned STACK_DEPTH = 256;
	localparam int unsigned RANDOM_PER_PHASE = 60;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = 10;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	request_t req = '0;
	logic     done;
	result_t  rsp;

	request_t    command_queue[$];
	result_t     stack_reports_due[$];
	entry_t      shadow_stack[STACK_DEPTH];
	int unsigned shadow_depth = 0;
	int unsigned planned_depth = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned stall_cycles = 0;
	result_t     report;
	result_t     due;

	tagged_operand_stack_engine_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	function automatic int unsigned operands_needed(cmd_t c);
		case (c)
			CMD_PUSH: return 0;
			CMD_SWAP: return 2;
			CMD_ROT:  return 3;
			default:  return 1;
		endcase
	endfunction

	task automatic execute_on_shadow_stack(input request_t r, output result_t res);
		entry_t      held;
		logic [63:0] index;
		int unsigned sp;
		err_t        err;
		sp = shadow_depth;
		err = ERR_OK;
		if (sp < operands_needed(r.cmd)) begin
			err = ERR_UNDER;
		end else begin
			case (r.cmd)
				CMD_PUSH: begin
					if (sp >= STACK_DEPTH) begin
						err = ERR_OVER;
					end else begin
						shadow_stack[sp].value = r.push_is_char ? {56'd0, r.push_value[7:0]}
							: r.push_value;
						shadow_stack[sp].is_char = r.push_is_char;
						sp++;
					end
				end
				CMD_DROP: sp--;
				CMD_DUP: begin
					if (sp >= STACK_DEPTH) begin
						err = ERR_OVER;
					end else begin
						shadow_stack[sp] = shadow_stack[sp - 1];
						sp++;
					end
				end
				CMD_SWAP: begin
					held = shadow_stack[sp - 1];
					shadow_stack[sp - 1] = shadow_stack[sp - 2];
					shadow_stack[sp - 2] = held;
				end
				CMD_ROT: begin
					held = shadow_stack[sp - 3];
					shadow_stack[sp - 3] = shadow_stack[sp - 2];
					shadow_stack[sp - 2] = shadow_stack[sp - 1];
					shadow_stack[sp - 1] = held;
				end
				CMD_PICK: begin
					// The index is unsigned here, so a negative one is always out of range.
					index = shadow_stack[sp - 1].value;
					if (index >= 64'(sp - 1))
						err = ERR_PICK;
					else
						shadow_stack[sp - 1] = shadow_stack[sp - 2 - int'(index[31:0])];
				end
				CMD_TO_INT: shadow_stack[sp - 1].is_char = 1'b0;
				default: begin
					shadow_stack[sp - 1].value = {56'd0, shadow_stack[sp - 1].value[7:0]};
					shadow_stack[sp - 1].is_char = 1'b1;
				end
			endcase
		end
		shadow_depth = sp;
		if (sp > 0) begin
			res.top_value = shadow_stack[sp - 1].value;
			res.top_is_char = shadow_stack[sp - 1].is_char;
		end else begin
			res.top_value = '0;
			res.top_is_char = 1'b0;
		end
		res.depth = sp[8:0];
		res.error = err;
	endtask

	task automatic queue_command(input cmd_t c, input logic [63:0] v, input logic ch);
		request_t item;
		item.cmd = c;
		item.push_value = v;
		item.push_is_char = ch;
		command_queue.push_back(item);
		case (c)
			CMD_PUSH: if (planned_depth < STACK_DEPTH) planned_depth++;
			CMD_DROP: if (planned_depth > 0) planned_depth--;
			CMD_DUP:  if (planned_depth > 0 && planned_depth < STACK_DEPTH) planned_depth++;
			default: ;
		endcase
	endtask

	function automatic logic [63:0] random_operand();
		case ($urandom_range(5))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(255));
			2: return 64'h7FFF_FFFF_FFFF_FFFF;
			3: return 64'h8000_0000_0000_0000;
			4: return -64'($urandom_range(1, 1000));
			default: return {32'hFFFF_FFFF, $urandom};
		endcase
	endfunction

	// Pushes, index-then-pick pairs whose index may be out of range, and other commands; drops favoured above depth 30.
	task automatic queue_random_commands(input int unsigned count);
		int unsigned made;
		int unsigned roll;
		int unsigned reach;
		made = 0;
		while (made < count) begin
			roll = $urandom_range(99);
			if (planned_depth > 30 && roll < 50) begin
				queue_command(CMD_DROP, random_operand(), 1'($urandom_range(1)));
				made++;
			end else if (roll < 30 || planned_depth < 2 && roll < 50) begin
				queue_command(CMD_PUSH, random_operand(), $urandom_range(3) == 0);
				made++;
			end else if (roll < 50) begin
				reach = planned_depth < 6 ? planned_depth : 6;
				if ($urandom_range(9) == 0)
					reach = planned_depth;
				queue_command(CMD_PUSH, 64'($urandom_range(reach)), $urandom_range(4) == 0);
				queue_command(CMD_PICK, random_operand(), 1'($urandom_range(1)));
				made += 2;
			end else begin
				queue_command(cmd_t'($urandom_range(1, 7)), random_operand(),
					1'($urandom_range(1)));
				made++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				execute_on_shadow_stack(req, report);
				stack_reports_due.push_back(report);
			end
			if (!start || !busy) begin
				if (command_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					req <= command_queue.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (stack_reports_due.size() == 0) begin
				$error("result with no request outstanding: top_value %h depth %0d",
					rsp.top_value, rsp.depth);
				mismatch_count++;
			end else begin
				due = stack_reports_due.pop_front();
				if (rsp.top_value !== due.top_value) begin
					$error("top_value: expected %h, got %h", due.top_value, rsp.top_value);
					mismatch_count++;
				end
				if (rsp.top_is_char !== due.top_is_char) begin
					$error("top_is_char: expected %b, got %b", due.top_is_char, rsp.top_is_char);
					mismatch_count++;
				end
				if (rsp.depth !== due.depth) begin
					$error("depth: expected %0d, got %0d", due.depth, rsp.depth);
					mismatch_count++;
				end
				if (rsp.error !== due.error) begin
					$error("error: expected %s, got %s", due.error.name(), rsp.error.name());
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (!start && stack_reports_due.size() == 0))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase;
		int unsigned idle_by_phase[4];
		idle_by_phase = '{0, 60, 0, 37};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Every command but push underflows on an empty stack.
		queue_command(CMD_DROP, 64'd0, 1'b0);
		queue_command(CMD_DUP, 64'd0, 1'b0);
		queue_command(CMD_SWAP, 64'd0, 1'b0);
		queue_command(CMD_ROT, 64'd0, 1'b0);
		queue_command(CMD_PICK, 64'd0, 1'b0);
		queue_command(CMD_TO_INT, 64'd0, 1'b0);
		queue_command(CMD_TO_CHAR, 64'd0, 1'b0);
		queue_command(CMD_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		queue_command(CMD_PUSH, 64'h8000_0000_0000_0000, 1'b0);
		queue_command(CMD_ROT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		queue_command(CMD_SWAP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		queue_command(CMD_PUSH, 64'hFFFF_FFFF_FFFF_FFA5, 1'b1);
		queue_command(CMD_ROT, 64'd0, 1'b0);
		queue_command(CMD_TO_CHAR, 64'd0, 1'b0);
		queue_command(CMD_TO_INT, 64'd0, 1'b0);
		queue_command(CMD_DUP, 64'd0, 1'b0);
		queue_command(CMD_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		queue_command(CMD_PICK, 64'd0, 1'b0);
		queue_command(CMD_DROP, 64'd0, 1'b0);
		queue_command(CMD_PUSH, 64'd0, 1'b0);
		queue_command(CMD_PICK, 64'd0, 1'b0);
		queue_command(CMD_PUSH, 64'(planned_depth), 1'b0);
		queue_command(CMD_PICK, 64'd0, 1'b0);
		queue_command(CMD_PUSH, 64'hFFFF_FFFF_FFFF_FF01, 1'b1);
		queue_command(CMD_PICK, 64'd0, 1'b0);

		for (phase = 0; phase < 4; phase++) begin
			sender_idle_pct = idle_by_phase[phase];
			if (phase == 1) begin
				// Fill to capacity, overflow, then pick from the very bottom.
				while (planned_depth < STACK_DEPTH)
					queue_command(CMD_PUSH, random_operand(), 1'($urandom_range(1)));
				queue_command(CMD_PUSH, random_operand(), 1'b0);
				queue_command(CMD_DUP, random_operand(), 1'b1);
				queue_command(CMD_DROP, 64'd0, 1'b0);
				queue_command(CMD_PUSH, 64'(STACK_DEPTH - 3), 1'b0);
				queue_command(CMD_PICK, 64'd0, 1'b0);
				queue_command(CMD_DROP, 64'd0, 1'b0);
				queue_command(CMD_PUSH, 64'(STACK_DEPTH - 2), 1'b1);
				queue_command(CMD_PICK, 64'd0, 1'b0);
				queue_command(CMD_DROP, 64'd0, 1'b0);
				queue_command(CMD_PUSH, 64'(STACK_DEPTH - 1), 1'b0);
				queue_command(CMD_PICK, 64'd0, 1'b0);
			end
			queue_random_commands(RANDOM_PER_PHASE);
			while (command_queue.size() != 0 || start || stack_reports_due.size() != 0)
				@(negedge clk);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

### tagged_operand_stack_engine_top.f
rtl/tose_pkg.sv
rtl/tose_cell.sv
rtl/tose_ctrl.sv
rtl/tagged_operand_stack_engine_top.sv
verif/tagged_operand_stack_engine_top_test.sv
